// ----- hw/rtl/gap_pkg.sv -----
// ----------------------------------------------------------------------------
// gap_pkg
// Shared constants, the free-rectangle record and the status codes of the
// guillotine atlas packer.
// ----------------------------------------------------------------------------
package gap_pkg;

    localparam int ATLAS_WIDTH    = 1024;
    localparam int ATLAS_HEIGHT   = 1024;
    localparam int MAX_FREE_RECTS = 64;

    // Request and result field widths
    localparam int GLYPH_BITS = 10;
    localparam int SLOT_BITS  = 10;
    localparam int COUNT_BITS = 7;

    // Padding added to the request size, and the padded size width
    localparam int PAD      = 2;
    localparam int PAD_BITS = GLYPH_BITS + 1;

    // Free-rectangle fields: corners below the atlas size, sizes up to it
    localparam int XW = $clog2(ATLAS_WIDTH);
    localparam int YW = $clog2(ATLAS_HEIGHT);
    localparam int WW = $clog2(ATLAS_WIDTH + 1);
    localparam int HW = $clog2(ATLAS_HEIGHT + 1);
    localparam int RECT_BITS = XW + YW + WW + HW;

    // Free-list index and fill count
    localparam int IDX_BITS = $clog2(MAX_FREE_RECTS);
    localparam int CNT_BITS = $clog2(MAX_FREE_RECTS + 1);

    // Compare widths for size against padded size
    localparam int CMP_W = (WW > PAD_BITS) ? WW : PAD_BITS;
    localparam int CMP_H = (HW > PAD_BITS) ? HW : PAD_BITS;

    // Sum widths for corner plus padded size
    localparam int SUM_X = ((XW > PAD_BITS) ? XW : PAD_BITS) + 1;
    localparam int SUM_Y = ((YW > PAD_BITS) ? YW : PAD_BITS) + 1;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [WW-1:0] w;
        logic [HW-1:0] h;
    } t_rect;

    typedef enum logic [1:0] {
        STATUS_PLACED   = 2'd0,
        STATUS_NO_FIT   = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

endpackage

// ----- hw/rtl/gap_req_if.sv -----
// ----------------------------------------------------------------------------
// gap_req_if
// Request channel of the atlas packer: unpadded glyph bitmap size.
// ----------------------------------------------------------------------------
interface gap_req_if;

    logic                            valid;
    logic                            ready;
    logic [gap_pkg::GLYPH_BITS-1:0]  glyph_width;
    logic [gap_pkg::GLYPH_BITS-1:0]  glyph_height;

    modport source (output valid, output glyph_width, output glyph_height, input ready);
    modport sink   (input valid, input glyph_width, input glyph_height, output ready);

endinterface

// ----- hw/rtl/gap_res_if.sv -----
// ----------------------------------------------------------------------------
// gap_res_if
// Result channel of the atlas packer: status, slot corner and list fill.
// ----------------------------------------------------------------------------
interface gap_res_if;

    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [gap_pkg::SLOT_BITS-1:0]   slot_x;
    logic [gap_pkg::SLOT_BITS-1:0]   slot_y;
    logic [gap_pkg::COUNT_BITS-1:0]  free_count;

    modport source (output valid, output status, output slot_x, output slot_y,
                    output free_count, input ready);
    modport sink   (input valid, input status, input slot_x, input slot_y,
                    input free_count, output ready);

endinterface

// ----- hw/rtl/gap_ram.sv -----
// ----------------------------------------------------------------------------
// gap_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/guillotine_atlas_packer.sv -----
// ----------------------------------------------------------------------------
// guillotine_atlas_packer
// First-fit guillotine allocator for glyph slots in a texture atlas.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                   Transfer when
//  -------  ---  ----------------------------------------  ------------------
//  i_req    in   glyph_width, glyph_height                 valid && ready
//  o_res    out  status, slot_x, slot_y, free_count        valid && ready
//
//  From transfer to result load: scan up to the first fit, compact the later
//  entries (not when the fit is the last), decide, append the lower and right
//  splits, load. A miss, an empty list or an overflow goes to the load early.
//  The next request can transfer in the cycle after the load. The free-list
//  RAM has a single read and a single write port, so entries move one by one.
//  Reset: one cycle after reset to write the whole atlas into entry 0.
//  Stalls: i_req is ready only between requests; a finished result waits in
//  the output register, and the next request is taken while it waits.
//
// ----------------------------------------------------------------------------
module guillotine_atlas_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gap_req_if.sink     i_req,
    gap_res_if.source   o_res
);

    localparam int XW        = gap_pkg::XW;
    localparam int YW        = gap_pkg::YW;
    localparam int WW        = gap_pkg::WW;
    localparam int HW        = gap_pkg::HW;
    localparam int PB        = gap_pkg::PAD_BITS;
    localparam int IB        = gap_pkg::IDX_BITS;
    localparam int CB        = gap_pkg::CNT_BITS;
    localparam int CB1       = gap_pkg::CNT_BITS + 1;
    localparam int CMPW      = gap_pkg::CMP_W;
    localparam int CMPH      = gap_pkg::CMP_H;
    localparam int SUMX      = gap_pkg::SUM_X;
    localparam int SUMY      = gap_pkg::SUM_Y;
    localparam int SB        = gap_pkg::SLOT_BITS;
    localparam int OB        = gap_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_APP_LOW,
        S_APP_RIGHT,
        S_RESULT
    } t_state;

    // ------------------------------------------------------------------
    // Registers and next values
    // ------------------------------------------------------------------
    t_state           r_state,      n_state;
    logic [PB-1:0]    r_pw,         n_pw;
    logic [PB-1:0]    r_ph,         n_ph;
    logic [CB-1:0]    r_count,      n_count;
    logic [CB-1:0]    r_n,          n_n;
    logic [IB-1:0]    r_idx,        n_idx;
    logic [IB-1:0]    r_last,       n_last;
    logic [IB-1:0]    r_pend_idx,   n_pend_idx;
    logic [IB-1:0]    r_sel,        n_sel;
    logic             r_issue,      n_issue;
    logic             r_pend,       n_pend;
    gap_pkg::t_rect   r_c,          n_c;
    gap_pkg::t_status r_res_status, n_res_status;
    logic [SB-1:0]    r_res_x,      n_res_x;
    logic [SB-1:0]    r_res_y,      n_res_y;
    logic             r_out_valid,  n_out_valid;
    gap_pkg::t_status r_out_status, n_out_status;
    logic [SB-1:0]    r_out_x,      n_out_x;
    logic [SB-1:0]    r_out_y,      n_out_y;
    logic [OB-1:0]    r_out_count,  n_out_count;

    // ------------------------------------------------------------------
    // Free-list RAM
    // ------------------------------------------------------------------
    logic                          ram_we;
    logic [IB-1:0]                 ram_waddr;
    gap_pkg::t_rect                ram_wdata;
    logic [gap_pkg::RECT_BITS-1:0] ram_rdata;
    gap_pkg::t_rect                ram_q;

    gap_ram #(
        .WIDTH (gap_pkg::RECT_BITS),
        .DEPTH (gap_pkg::MAX_FREE_RECTS)
    ) u_free_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign ram_q = gap_pkg::t_rect'(ram_rdata);

    // ------------------------------------------------------------------
    // Shared arithmetic on the chosen rectangle and the padded size
    // ------------------------------------------------------------------
    logic            req_fire;
    logic            out_free;
    logic            fit;
    logic [CB-1:0]   cnt_m1;
    logic [CMPH-1:0] low_h_full;
    logic [CMPW-1:0] right_w_full;
    logic [HW-1:0]   low_h;
    logic [WW-1:0]   right_w;
    logic            has_low;
    logic            has_right;
    logic [CB1-1:0]  need;
    logic            overflow;
    logic [SUMY-1:0] low_y_full;
    logic [SUMX-1:0] right_x_full;
    logic [CMPW-1:0] pw_ext;
    logic [SB+XW-1:0] slot_x_ext;
    logic [SB+YW-1:0] slot_y_ext;
    logic [OB+CB-1:0] count_ext;

    assign req_fire = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;

    // A pending read data word fits when both sides cover the padded size
    assign fit = r_pend
              && (CMPW'(ram_q.w) >= CMPW'(r_pw))
              && (CMPH'(ram_q.h) >= CMPH'(r_ph));

    assign cnt_m1       = r_count - CB'(1);
    assign low_h_full   = CMPH'(r_c.h) - CMPH'(r_ph);
    assign right_w_full = CMPW'(r_c.w) - CMPW'(r_pw);
    assign low_h        = low_h_full[HW-1:0];
    assign right_w      = right_w_full[WW-1:0];
    assign has_low      = (low_h != '0);
    assign has_right    = (right_w != '0);

    // Entries left after removal plus the splits must still fit in the list
    assign need     = CB1'(r_count) - CB1'(1) + CB1'(has_low) + CB1'(has_right);
    assign overflow = (need > CB1'(gap_pkg::MAX_FREE_RECTS));

    assign low_y_full   = SUMY'(r_c.y) + SUMY'(r_ph);
    assign right_x_full = SUMX'(r_c.x) + SUMX'(r_pw);
    assign pw_ext       = CMPW'(r_pw);

    // Fit result fields to their port widths
    assign slot_x_ext = {{SB{1'b0}}, r_c.x};
    assign slot_y_ext = {{SB{1'b0}}, r_c.y};
    assign count_ext  = {{OB{1'b0}}, r_count};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_pw         = r_pw;
        n_ph         = r_ph;
        n_count      = r_count;
        n_n          = r_n;
        n_idx        = r_idx;
        n_last       = r_last;
        n_pend_idx   = r_pend_idx;
        n_sel        = r_sel;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_c          = r_c;
        n_res_status = r_res_status;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;

        // Drop the held result once it transfers
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                // Seed entry 0 with the whole atlas
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata.x = '0;
                ram_wdata.y = '0;
                ram_wdata.w = WW'(gap_pkg::ATLAS_WIDTH);
                ram_wdata.h = HW'(gap_pkg::ATLAS_HEIGHT);
                n_state     = S_IDLE;
            end

            S_IDLE: begin
                if (req_fire) begin
                    n_pw    = PB'(i_req.glyph_width) + PB'(gap_pkg::PAD);
                    n_ph    = PB'(i_req.glyph_height) + PB'(gap_pkg::PAD);
                    n_res_x = '0;
                    n_res_y = '0;
                    if (r_count == '0) begin
                        n_res_status = gap_pkg::STATUS_NO_FIT;
                        n_state      = S_RESULT;
                    end else begin
                        n_idx   = '0;
                        n_last  = cnt_m1[IB-1:0];
                        n_issue = 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // One read issued and one compared per cycle
                if (fit) begin
                    n_c     = ram_q;
                    n_sel   = r_pend_idx;
                    n_pend  = 1'b0;
                    n_state = S_DECIDE;
                end else if (r_pend && (r_pend_idx == r_last)) begin
                    n_pend       = 1'b0;
                    n_res_status = gap_pkg::STATUS_NO_FIT;
                    n_state      = S_RESULT;
                end else begin
                    n_pend     = r_issue;
                    n_pend_idx = r_idx;
                    if (r_issue) begin
                        n_idx   = r_idx + IB'(1);
                        n_issue = (r_idx != r_last);
                    end
                end
            end

            S_DECIDE: begin
                if (overflow) begin
                    n_res_status = gap_pkg::STATUS_OVERFLOW;
                    n_state      = S_RESULT;
                end else begin
                    n_res_x = slot_x_ext[SB-1:0];
                    n_res_y = slot_y_ext[SB-1:0];
                    n_n     = cnt_m1;
                    if (r_sel == r_last) begin
                        n_state = S_APP_LOW;
                    end else begin
                        n_idx   = r_sel + IB'(1);
                        n_issue = 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                // Move each later entry down one place
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_idx - IB'(1);
                    ram_wdata = ram_q;
                end
                if (r_pend && (r_pend_idx == r_last)) begin
                    n_pend  = 1'b0;
                    n_state = S_APP_LOW;
                end else begin
                    n_pend     = r_issue;
                    n_pend_idx = r_idx;
                    if (r_issue) begin
                        n_idx   = r_idx + IB'(1);
                        n_issue = (r_idx != r_last);
                    end
                end
            end

            S_APP_LOW: begin
                if (has_low) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_n[IB-1:0];
                    ram_wdata.x = r_c.x;
                    ram_wdata.y = low_y_full[YW-1:0];
                    ram_wdata.w = pw_ext[WW-1:0];
                    ram_wdata.h = low_h;
                    n_n         = r_n + CB'(1);
                end
                n_state = S_APP_RIGHT;
            end

            S_APP_RIGHT: begin
                if (has_right) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_n[IB-1:0];
                    ram_wdata.x = right_x_full[XW-1:0];
                    ram_wdata.y = r_c.y;
                    ram_wdata.w = right_w;
                    ram_wdata.h = r_c.h;
                end
                n_count      = r_n + CB'(has_right);
                n_res_status = gap_pkg::STATUS_PLACED;
                n_state      = S_RESULT;
            end

            S_RESULT: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_x      = r_res_x;
                    n_out_y      = r_res_y;
                    n_out_count  = count_ext[OB-1:0];
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CB'(1);
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_pw         <= n_pw;
        r_ph         <= n_ph;
        r_n          <= n_n;
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_pend_idx   <= n_pend_idx;
        r_sel        <= n_sel;
        r_c          <= n_c;
        r_res_status <= n_res_status;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_out_status <= n_out_status;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_count  <= n_out_count;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.slot_x     = r_out_x;
    assign o_res.slot_y     = r_out_y;
    assign o_res.free_count = r_out_count;

`ifndef ASSERT_OFF
    // The list fill never passes its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(gap_pkg::MAX_FREE_RECTS))
        else $error("free list count above capacity");

    // An accepted request either starts the scan or goes straight to result
    a_req_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == S_SCAN) || (r_state == S_RESULT))
        else $error("request did not start a search");

    // A failed request reports a zero corner
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != gap_pkg::STATUS_PLACED))
        |-> (o_res.slot_x == '0) && (o_res.slot_y == '0))
        else $error("nonzero corner on a failed request");

    // The fill count only changes when a placement completes
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count))
        |-> (($past(r_state) == S_APP_RIGHT) || !$past(i_rst_n)))
        else $error("free list count changed outside a placement");
`endif

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the guillotine atlas packer. A queue of glyph
// sizes feeds a clocked request driver, and every transfer is run through a
// first-fit free-list tracker that keeps its own copy of the list. A clocked
// monitor compares each result transfer with the oldest predicted slot.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GLYPH_BITS     = gap_pkg::GLYPH_BITS;
    localparam int SLOT_BITS      = gap_pkg::SLOT_BITS;
    localparam int COUNT_BITS     = gap_pkg::COUNT_BITS;
    localparam int PAD            = gap_pkg::PAD;
    localparam int MAX_FREE_RECTS = gap_pkg::MAX_FREE_RECTS;
    localparam int ATLAS_WIDTH    = gap_pkg::ATLAS_WIDTH;
    localparam int ATLAS_HEIGHT   = gap_pkg::ATLAS_HEIGHT;

    // One free rectangle as tracked by the bench
    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } t_area;

    // One request waiting for the driver
    typedef struct {
        logic [GLYPH_BITS-1:0] w;
        logic [GLYPH_BITS-1:0] h;
    } t_glyph;

    // One predicted result
    typedef struct {
        gap_pkg::t_status      status;
        logic [SLOT_BITS-1:0]  slot_x;
        logic [SLOT_BITS-1:0]  slot_y;
        logic [COUNT_BITS-1:0] free_count;
    } t_slot;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_AFTER   = 300;   // transfers before the long receiver hold-off
    localparam int HOLD_CYCLES  = 500;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gap_req_if req_if();
    gap_res_if res_if();

    // Bench-side drive registers, known from time zero
    logic                  req_valid = 1'b0;
    logic [GLYPH_BITS-1:0] req_w     = '0;
    logic [GLYPH_BITS-1:0] req_h     = '0;
    logic                  res_ready = 1'b0;

    assign req_if.valid        = req_valid;
    assign req_if.glyph_width  = req_w;
    assign req_if.glyph_height = req_h;
    assign res_if.ready        = res_ready;

    guillotine_atlas_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Free-list tracker state
    t_area  free_list [MAX_FREE_RECTS];
    int     free_cnt;

    t_glyph glyph_q[$];     // sizes not yet offered
    t_slot  slot_q[$];      // predicted results, oldest first

    int     req_acc   = 0;  // request transfers so far
    int     bad_cnt   = 0;  // mismatches and unexpected results
    int     req_idle  = 0;
    int     res_stall = 0;
    int     hold_cnt  = 0;
    bit     hold_done = 1'b0;
    bit     calm      = 1'b1;
    int     calm_left = 0;

    // Append one size to the tail of the request queue
    function automatic void add_glyph(input logic [GLYPH_BITS-1:0] gw,
                                      input logic [GLYPH_BITS-1:0] gh);
        t_glyph g;
        g.w = gw;
        g.h = gh;
        glyph_q.insert(glyph_q.size(), g);
    endfunction

    // ------------------------------------------------------------------------
    // First-fit placement on the tracked free list. Pad both sides, take the
    // first entry that is large enough, compact the list, then append the
    // lower split and the right split. On no fit or on overflow leave the
    // list alone.
    // ------------------------------------------------------------------------
    function automatic t_slot place_glyph(input logic [GLYPH_BITS-1:0] gw,
                                          input logic [GLYPH_BITS-1:0] gh);
        int    pw;
        int    ph;
        int    n;
        int    hit;
        int    low_h;
        int    right_w;
        int    splits;
        t_area c;
        t_slot r;
        pw  = int'(gw) + PAD;
        ph  = int'(gh) + PAD;
        n   = free_cnt;
        hit = -1;
        r.status = gap_pkg::STATUS_NO_FIT;
        r.slot_x = '0;
        r.slot_y = '0;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && free_list[i].w >= pw && free_list[i].h >= ph) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            c       = free_list[hit];
            low_h   = c.h - ph;
            right_w = c.w - pw;
            splits  = 0;
            if (low_h != 0) splits++;
            if (right_w != 0) splits++;
            if (n - 1 + splits > MAX_FREE_RECTS) begin
                r.status = gap_pkg::STATUS_OVERFLOW;
            end else begin
                r.status = gap_pkg::STATUS_PLACED;
                r.slot_x = SLOT_BITS'(c.x);
                r.slot_y = SLOT_BITS'(c.y);
                // compact: later entries move down one place in order
                for (int i = hit; i < n - 1; i++) begin
                    free_list[i] = free_list[i + 1];
                end
                n--;
                if (low_h != 0) begin
                    free_list[n] = '{c.x, c.y + ph, pw, low_h};
                    n++;
                end
                if (right_w != 0) begin
                    free_list[n] = '{c.x + pw, c.y, right_w, c.h};
                    n++;
                end
                free_cnt = n;
            end
        end
        r.free_count = COUNT_BITS'(free_cnt);
        return r;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // ------------------------------------------------------------------------
    // Random glyph size. Lean on tiny glyphs, most of all early on, so the list
    // fills up and overflow shows; also mix in exact fits (whole or one side) on
    // live entries so the list also shrinks, plus wide and full-range sizes.
    // ------------------------------------------------------------------------
    function automatic t_glyph pick_glyph(input int idx);
        t_glyph g;
        t_area  a;
        int     r;
        int     tiny;
        r    = $urandom_range(0, 99);
        tiny = (idx < 200) ? 60 : 30;
        g.w  = GLYPH_BITS'($urandom_range(0, 8));
        g.h  = GLYPH_BITS'($urandom_range(0, 8));
        if (r >= tiny && r < tiny + 20 && free_cnt > 0) begin
            a = free_list[$urandom_range(0, free_cnt - 1)];
            if (a.w >= PAD && a.h >= PAD) begin
                g.w = GLYPH_BITS'(a.w - PAD);
                g.h = GLYPH_BITS'(a.h - PAD);
                case ($urandom_range(0, 2))
                    0: g.w = GLYPH_BITS'($urandom_range(0, a.w - PAD));
                    1: g.h = GLYPH_BITS'($urandom_range(0, a.h - PAD));
                    default: ;
                endcase
            end
        end else if (r >= tiny + 20 && r < tiny + 28) begin
            g.w = GLYPH_BITS'($urandom_range(0, 1022));
            g.h = GLYPH_BITS'($urandom_range(0, 1022));
        end else if (r >= tiny + 28) begin
            g.w = GLYPH_BITS'($urandom_range(0, 120));
            g.h = GLYPH_BITS'($urandom_range(0, 120));
        end
        return g;
    endfunction

    // Hold until every request is through and every result is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (glyph_q.size() != 0 || req_valid || slot_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: present the next queued size, hold it until transfer,
    // predict the result on transfer, and insert random idle cycles.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_req
        t_glyph nxt;
        t_slot  pred;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            req_idle  <= 0;
        end else begin
            if (req_valid && req_if.ready) begin
                pred = place_glyph(req_w, req_h);
                slot_q.insert(slot_q.size(), pred);
                req_acc <= req_acc + 1;
            end
            // advance only when nothing is held or the held item just went
            if (!req_valid || req_if.ready) begin
                if (req_idle != 0) begin
                    req_idle  <= req_idle - 1;
                    req_valid <= 1'b0;
                end else if (glyph_q.size() != 0) begin
                    nxt       = glyph_q.pop_front();
                    req_w     <= nxt.w;
                    req_h     <= nxt.h;
                    req_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 99) < 30) begin
                        req_idle <= pick_gap();
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Alternate stretches with and without idling on both sides
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            calm      <= 1'b1;
            calm_left <= 60;
        end else if (calm_left == 0) begin
            calm      <= !calm;
            calm_left <= $urandom_range(40, 400);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // One long receiver hold-off while the driver keeps offering, so the
    // packer fills its output register and drops ready on the request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && req_acc >= HOLD_AFTER) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    function automatic bit res_valid_ok();
        return res_if.valid === 1'b1 && res_ready;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor: drive ready with random stalls, and on each transfer
    // compare every field with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_res
        t_slot exp_slot;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            res_stall <= 0;
        end else begin
            if (res_valid_ok()) begin
                if (slot_q.size() == 0) begin
                    if (bad_cnt < 10) begin
                        $display("%0t: result with nothing predicted:", $realtime,
                                 " st=%0d x=%0d y=%0d n=%0d",
                                 res_if.status, res_if.slot_x, res_if.slot_y,
                                 res_if.free_count);
                    end
                    bad_cnt <= bad_cnt + 1;
                end else begin
                    exp_slot = slot_q.pop_front();
                    if (res_if.status !== exp_slot.status ||
                        res_if.slot_x !== exp_slot.slot_x ||
                        res_if.slot_y !== exp_slot.slot_y ||
                        res_if.free_count !== exp_slot.free_count) begin
                        if (bad_cnt < 10) begin
                            $display("%0t: mismatch exp st=%0d x=%0d y=%0d n=%0d",
                                     $realtime, exp_slot.status, exp_slot.slot_x,
                                     exp_slot.slot_y, exp_slot.free_count,
                                     " got st=%0d x=%0d y=%0d n=%0d",
                                     res_if.status, res_if.slot_x, res_if.slot_y,
                                     res_if.free_count);
                        end
                        bad_cnt <= bad_cnt + 1;
                    end
                end
            end
            if (hold_cnt != 0) begin
                res_ready <= 1'b0;
            end else if (res_stall != 0) begin
                res_stall <= res_stall - 1;
                res_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 15) begin
                res_stall <= pick_gap() - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed corners, random traffic, then a drain that
    // removes entries by exact fits and, if the list empties, ends with a request on it.
    // ------------------------------------------------------------------------
    initial begin
        t_glyph g;
        int     pick;
        free_list[0] = '{0, 0, ATLAS_WIDTH, ATLAS_HEIGHT};
        free_cnt     = 1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full width, thinnest slot: lower split only
        add_glyph(10'd1022, 10'd0);
        // too tall for what is left, then the largest size: no fit
        add_glyph(10'd0, 10'd1022);
        add_glyph(10'd1022, 10'd1022);
        // full remaining height: right split only
        add_glyph(10'd0, 10'd1020);
        // smallest glyph: both splits
        add_glyph(10'd0, 10'd0);
        // exact fit of the thin lower split: list shrinks
        add_glyph(10'd0, 10'd1018);
        add_glyph(10'd1021, 10'd0);
        add_glyph(10'd1, 10'd1);
        // alternating bit patterns
        add_glyph(10'd341, 10'd682);
        add_glyph(10'd682, 10'd341);
        add_glyph(10'd511, 10'd512);
        add_glyph(10'd512, 10'd511);
        add_glyph(10'd1, 10'd1022);
        add_glyph(10'd1022, 10'd1);
        add_glyph(10'd3, 10'd5);

        // random part: keep the queue short so picks see a fresh list
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            do @(negedge i_clk);
            while (glyph_q.size() >= 2);
            g = pick_glyph(i);
            add_glyph(g.w, g.h);
        end

        // drain by exact fits, one at a time on an idle packer
        for (int i = 0; i < 100; i++) begin
            wait_idle();
            if (free_cnt == 0) begin
                add_glyph(10'd0, 10'd0);
                break;
            end
            pick = -1;
            for (int k = 0; k < free_cnt; k++) begin
                if (pick < 0 && free_list[k].w >= PAD && free_list[k].h >= PAD) pick = k;
            end
            if (pick < 0) break;
            add_glyph(GLYPH_BITS'(free_list[pick].w - PAD),
                      GLYPH_BITS'(free_list[pick].h - PAD));
        end

        wait_idle();
        repeat (100) @(negedge i_clk);
        if (bad_cnt == 0 && slot_q.size() == 0) begin
            $display("PASS guillotine_atlas_packer");
        end else begin
            $display("FAIL guillotine_atlas_packer");
        end
        $finish;
    end

    // Timeout
    initial begin
        #10ms;
        $display("FAIL guillotine_atlas_packer");
        $finish;
    end

endmodule

// ----- guillotine_atlas_packer.f -----
hw/rtl/gap_pkg.sv
hw/rtl/gap_req_if.sv
hw/rtl/gap_res_if.sv
hw/rtl/gap_ram.sv
hw/rtl/guillotine_atlas_packer.sv
sim/tb.sv
